@@ sv/fnc_pkg.sv @@
// Shared types and constants for the frequency to note converter.
// Used by every module of the block; depends on nothing.
package fnc_pkg;

  localparam int FREQ_WIDTH_DEF  = 24;
  localparam int FREQ_FRAC_DEF   = 8;
  localparam int OFFSET_FRAC_DEF = 8;

  localparam int LOG_FRAC     = 24;
  localparam int EXP_W        = 5;
  localparam int MANT_W       = 32;
  localparam int LOG2_440_Q24 = 147326769;
  localparam int A4_MIDI      = 69;
  localparam int SEMIS        = 12;
  localparam int MIDI_W       = 11;
  localparam int NQ_W         = 36;
  localparam int OCT_BIAS     = 86;
  localparam int RECIP12      = 2731;
  localparam int RECIP_SHIFT  = 15;

  typedef struct packed {
    logic                zero;
    logic [EXP_W-1:0]    e;
    logic [LOG_FRAC-1:0] frac;
    logic [MANT_W-1:0]   m;
  } log_t;

  typedef struct packed {
    logic              bad;
    logic signed [8:0] midi;
    logic [3:0]        idx;
    logic signed [4:0] oct;
    logic signed [8:0] off;
  } res_t;

endpackage

@@ sv/fnc_norm.sv @@
// Front end: leading-one search and mantissa normalization, two register stages.
// Depends on fnc_pkg.
module fnc_norm import fnc_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [FREQ_WIDTH-1:0] data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output log_t                  data_o
);

  logic [1:0]            v_q;
  logic [1:0]            rdy;
  logic [EXP_W-1:0]      e_d, e_q;
  logic [FREQ_WIDTH-1:0] f_q;
  logic                  zero_q;
  log_t                  out_d, out_q;

  assign rdy[1]  = ~v_q[1] | ready_i;
  assign rdy[0]  = ~v_q[0] | rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[1];
  assign data_o  = out_q;

  always_comb begin
    e_d = '0;
    for (int i = 0; i < FREQ_WIDTH; i++) begin
      if (data_i[i]) e_d = EXP_W'(i);
    end
  end

  always_comb begin
    out_d.zero = zero_q;
    out_d.e    = e_q;
    out_d.frac = '0;
    out_d.m    = MANT_W'(f_q) << (EXP_W'(MANT_W - 1) - e_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      e_q    <= e_d;
      f_q    <= data_i;
      zero_q <= ~|data_i;
    end
    if (rdy[1]) out_q <= out_d;
  end

endmodule

@@ sv/fnc_sq_stage.sv @@
// One fraction bit of the base-2 logarithm: square the mantissa, test, renormalize.
// Depends on fnc_pkg.
module fnc_sq_stage import fnc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  log_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output log_t data_o
);

  logic                v_q;
  logic [2*MANT_W-1:0] prod;
  logic                bit_d;
  log_t                out_d, out_q;

  assign ready_o = ~v_q | ready_i;
  assign valid_o = v_q;
  assign data_o  = out_q;

  always_comb begin
    prod       = {{MANT_W{1'b0}}, data_i.m} * {{MANT_W{1'b0}}, data_i.m};
    bit_d      = prod[2*MANT_W-1];
    out_d.zero = data_i.zero;
    out_d.e    = data_i.e;
    out_d.frac = {data_i.frac[LOG_FRAC-2:0], bit_d};
    out_d.m    = bit_d ? prod[2*MANT_W-1:MANT_W] : prod[2*MANT_W-2:MANT_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) out_q <= out_d;
  end

endmodule

@@ sv/fnc_post.sv @@
// Back end: semitone distance, rounding, offset, note index and octave, five stages.
// Depends on fnc_pkg.
module fnc_post import fnc_pkg::*; #(
  parameter int FREQ_FRAC_BITS   = FREQ_FRAC_DEF,
  parameter int OFFSET_FRAC_BITS = OFFSET_FRAC_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  log_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  localparam int          Shift     = LOG_FRAC - OFFSET_FRAC_BITS;
  localparam logic [24:0] RoundHalf = 25'(1) << (Shift - 1);
  localparam logic signed [31:0] DBias =
    32'(FREQ_FRAC_BITS * (1 << LOG_FRAC)) + 32'(LOG2_440_Q24);

  logic [4:0] v_q;
  logic [4:0] rdy;
  logic [3:0] zero_q;

  // stage 1
  logic signed [31:0] d_d, d_q;
  // stage 2
  logic signed [NQ_W-1:0] dx, nq_d, nq_q;
  // stage 3
  logic [NQ_W-1:0] a, sum;
  logic            neg_q;
  logic [11:0]     q_q;
  logic [23:0]     tm_q;
  // stage 4
  logic [MIDI_W-1:0] midi_d, midi_q;
  logic              tm_neg;
  logic [23:0]       tm_abs;
  logic [24:0]       om, off_full;
  logic [8:0]        off_q;
  // stage 5
  logic [11:0] um;
  logic [23:0] qp;
  logic [7:0]  q8;
  res_t        res_d, res_q;

  assign rdy[4]  = ~v_q[4] | ready_i;
  assign rdy[3]  = ~v_q[3] | rdy[4];
  assign rdy[2]  = ~v_q[2] | rdy[3];
  assign rdy[1]  = ~v_q[1] | rdy[2];
  assign rdy[0]  = ~v_q[0] | rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[4];
  assign data_o  = res_q;

  always_comb begin
    d_d  = $signed({3'b000, data_i.e, data_i.frac}) - DBias;
    dx   = {{(NQ_W-32){d_q[31]}}, d_q};
    nq_d = (dx <<< 3) + (dx <<< 2);
    a    = nq_q[NQ_W-1] ? NQ_W'(-nq_q) : nq_q;
    sum  = a + NQ_W'(1 << (LOG_FRAC - 1));
  end

  always_comb begin
    midi_d   = MIDI_W'(A4_MIDI) + (neg_q ? MIDI_W'(-{1'b0, q_q}) : MIDI_W'(q_q));
    tm_neg   = tm_q[23];
    tm_abs   = tm_neg ? 24'(-tm_q) : tm_q;
    om       = (25'(tm_abs) + RoundHalf) >> Shift;
    off_full = (neg_q ^ tm_neg) ? 25'(-om) : om;
  end

  always_comb begin
    um = {midi_q[MIDI_W-1], midi_q} + 12'(OCT_BIAS * SEMIS);
    qp = 24'(um) * 24'(RECIP12);
    q8 = qp[RECIP_SHIFT+7:RECIP_SHIFT];
    if (zero_q[3]) begin
      res_d = '0;
      res_d.bad = 1'b1;
    end else begin
      res_d.bad  = 1'b0;
      res_d.midi = midi_q[8:0];
      res_d.idx  = 4'(um - {4'b0000, q8} * 12'(SEMIS));
      res_d.oct  = 5'(q8 - 8'(OCT_BIAS + 1));
      res_d.off  = off_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      d_q       <= d_d;
      zero_q[0] <= data_i.zero;
    end
    if (rdy[1]) begin
      nq_q      <= nq_d;
      zero_q[1] <= zero_q[0];
    end
    if (rdy[2]) begin
      neg_q     <= nq_q[NQ_W-1];
      q_q       <= sum[LOG_FRAC+11:LOG_FRAC];
      tm_q      <= {~sum[LOG_FRAC-1], sum[LOG_FRAC-2:0]};
      zero_q[2] <= zero_q[1];
    end
    if (rdy[3]) begin
      midi_q    <= midi_d;
      off_q     <= off_full[8:0];
      zero_q[3] <= zero_q[2];
    end
    if (rdy[4]) begin
      res_q     <= res_d;
    end
  end

endmodule

@@ sv/frequency_to_note_converter.sv @@
// Top level of the frequency to note converter: normalizer, logarithm chain, back end.
// Depends on fnc_pkg, fnc_norm, fnc_sq_stage and fnc_post.
//
// Converts a frequency word (1/2^FREQ_FRAC_BITS Hz) into the nearest equal-tempered
// MIDI note (A4 = 440 Hz = 69), its note index within the octave (C = 0), its octave
// and the leftover offset in 1/2^OFFSET_FRAC_BITS semitone. A zero frequency sets
// tuser and clears all tdata fields. The block takes one word per clock while the
// output is not stalled. Each result passes leading-one search and normalization,
// then the logarithm (one 32x32 squaring unit per fraction bit), then rounding and
// the octave split. Every stage has its own valid bit, so bubbles close up under
// output backpressure.
module frequency_to_note_converter import fnc_pkg::*; #(
  parameter int FREQ_WIDTH       = FREQ_WIDTH_DEF,
  parameter int FREQ_FRAC_BITS   = FREQ_FRAC_DEF,
  parameter int OFFSET_FRAC_BITS = OFFSET_FRAC_DEF,
  localparam int InDataW         = ((FREQ_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // freq_units
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // midi_note, pitch_class, octave_number,
                                            // semitone_offset
  output logic               m_axis_tuser   // bad_input
);

  logic             v   [LOG_FRAC+1];
  logic             rdy [LOG_FRAC+1];
  log_t             lg  [LOG_FRAC+1];
  logic             post_ready;
  res_t             res;

  fnc_norm #(
    .FREQ_WIDTH(FREQ_WIDTH)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .data_i (s_axis_tdata[FREQ_WIDTH-1:0]),
    .valid_o(v[0]),
    .ready_i(rdy[0]),
    .data_o (lg[0])
  );

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    fnc_sq_stage u_sq (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v[k]),
      .ready_o(rdy[k]),
      .data_i (lg[k]),
      .valid_o(v[k+1]),
      .ready_i(rdy[k+1]),
      .data_o (lg[k+1])
    );
  end

  assign rdy[LOG_FRAC] = post_ready;

  fnc_post #(
    .FREQ_FRAC_BITS  (FREQ_FRAC_BITS),
    .OFFSET_FRAC_BITS(OFFSET_FRAC_BITS)
  ) u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v[LOG_FRAC]),
    .ready_o(post_ready),
    .data_i (lg[LOG_FRAC]),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (res)
  );

  assign m_axis_tdata = {5'b00000, res.off, res.oct, res.idx, res.midi};
  assign m_axis_tuser = res.bad;

endmodule
